// File: rtl/core/drf_pkg.sv
// Shared types and codes for the two-reader record FIFO.
package drf_pkg;

    // Field widths of one record.
    localparam int ID_W  = 16;
    localparam int PAY_W = 64;
    localparam int REC_W = ID_W + PAY_W;

    // Request kinds carried in the slave-side tuser.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status codes carried in the master-side tuser.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NODATA = 2'd1,
        ST_RETRY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic direct;  // beat answered at once from the control state
        logic fetch;   // remove beat that starts a head read
        logic finish;  // head read data is back, complete the remove
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;  // the offered beat must read the head record
        logic empty;
        logic full;
    } dp_status_t;

endpackage

// File: rtl/core/dual_reader_fifo.sv
// Top level of the two-reader record FIFO: stream ports, controller and datapath.
// Results are registered; a record-returning remove first passes the RAM's registered read
// port. Throughput: one beat per cycle for inserts and status-only removes while the result
// slot frees; a record-returning remove holds the input while the read port delivers.
// Reset (rst_n, asynchronous, active low) clears pointers, count, read marks, end-of-stream
// and result valid; RAM contents are not cleared and are only read after being written.
module dual_reader_fifo #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [15:0] sensor_id, [79:16] record_payload
    input  logic [1:0]  s_tuser,   // [0] mode, [1] consumer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] out_sensor_id, [79:16] out_payload
    output logic [1:0]  m_tuser    // [1:0] status
);

    drf_pkg::cmd_t       cmd;
    drf_pkg::dp_status_t dp_st;
    drf_pkg::status_t    out_status;

    drf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_st    (dp_st),
        .cmd      (cmd)
    );

    drf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_st         (dp_st),
        .in_mode       (s_tuser[0]),
        .in_consumer   (s_tuser[1]),
        .in_sensor_id  (s_tdata[15:0]),
        .in_payload    (s_tdata[79:16]),
        .out_status    (out_status),
        .out_sensor_id (m_tdata[15:0]),
        .out_payload   (m_tdata[79:16])
    );

    assign m_tuser = out_status;

    // A record-returning remove blocks the next beat while its head read is in progress.
    a_fetch_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |=> !s_tready)
        else $error("input accepted during head read");

    // Every accepted beat yields a result; a head read presents it after the fetch state.
    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.direct |=> m_tvalid)
        else $error("direct result not presented");

    a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |=> ##1 m_tvalid)
        else $error("read result not presented");

    // The FIFO cannot be empty and full at once.
    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_st.empty && dp_st.full))
        else $error("fill count inconsistent");

endmodule

// File: rtl/core/drf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module drf_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/drf_ctrl.sv
// Controller state machine: beat acceptance, head read sequencing, result valid.
module drf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  drf_pkg::dp_status_t dp_st,
    output drf_pkg::cmd_t       cmd
);

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;

    // A new beat is taken only when idle and the result slot frees up this cycle.
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Commands to the datapath.
    always_comb
    begin
        cmd.direct = take && !dp_st.need_read;
        cmd.fetch  = take && dp_st.need_read;
        cmd.finish = (state_reg == S_FETCH);
    end

    // Next state and result valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.fetch)
                begin
                    state_next = S_FETCH;
                end
                if (cmd.direct)
                begin
                    out_valid_next = 1'b1;
                end
            end
            S_FETCH:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/drf_dp.sv
// Datapath: record RAM, head and tail pointers, fill count, read marks, result register.
module drf_dp #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  drf_pkg::cmd_t             cmd,
    output drf_pkg::dp_status_t       dp_st,
    input  logic                      in_mode,
    input  logic                      in_consumer,
    input  logic [drf_pkg::ID_W-1:0]  in_sensor_id,
    input  logic [drf_pkg::PAY_W-1:0] in_payload,
    output drf_pkg::status_t          out_status,
    output logic [drf_pkg::ID_W-1:0]  out_sensor_id,
    output logic [drf_pkg::PAY_W-1:0] out_payload
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       marks_reg, marks_next;
    logic             eos_reg, eos_next;
    logic             who_reg;

    drf_pkg::status_t          status_reg, status_next;
    logic [drf_pkg::ID_W-1:0]  id_reg, id_next;
    logic [drf_pkg::PAY_W-1:0] pay_reg, pay_next;

    logic                      empty, full, wr_en;
    logic [1:0]                in_mark, rd_mark, merged_marks;
    logic [drf_pkg::REC_W-1:0] rd_data;
    logic [drf_pkg::ID_W-1:0]  rd_id;

    // Status toward the controller.
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign in_mark = in_consumer ? 2'b10 : 2'b01;
    always_comb
    begin
        dp_st.empty     = empty;
        dp_st.full      = full;
        dp_st.need_read = (in_mode == drf_pkg::MODE_REMOVE) && !empty
                          && ((marks_reg & in_mark) == 2'b00);
    end

    // Record storage: id in the low bits, payload above.
    assign wr_en = cmd.direct && (in_mode == drf_pkg::MODE_INSERT) && !full;

    drf_ram #(
        .WIDTH (drf_pkg::REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data ({in_payload, in_sensor_id}),
        .rd_en   (cmd.fetch),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign rd_id        = rd_data[drf_pkg::ID_W-1:0];
    assign rd_mark      = who_reg ? 2'b10 : 2'b01;
    assign merged_marks = marks_reg | rd_mark;

    // Pointer, mark and result updates.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        marks_next  = marks_reg;
        eos_next    = eos_reg;
        status_next = status_reg;
        id_next     = id_reg;
        pay_next    = pay_reg;
        if (cmd.direct)
        begin
            id_next  = '0;
            pay_next = '0;
            if (in_mode == drf_pkg::MODE_INSERT)
            begin
                if (full)
                begin
                    status_next = drf_pkg::ST_FULL;
                end
                else
                begin
                    status_next = drf_pkg::ST_OK;
                    tail_next   = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            else if (empty && eos_reg)
            begin
                status_next = drf_pkg::ST_NODATA;
            end
            else
            begin
                status_next = drf_pkg::ST_RETRY;
            end
        end
        if (cmd.finish)
        begin
            id_next     = rd_id;
            pay_next    = rd_data[drf_pkg::REC_W-1:drf_pkg::ID_W];
            status_next = drf_pkg::ST_OK;
            if (rd_id == '0)
            begin
                eos_next    = 1'b1;
                status_next = drf_pkg::ST_NODATA;
            end
            // Pop the head once both consumers have read it.
            if (merged_marks == 2'b11)
            begin
                marks_next = 2'b00;
                head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
            end
            else
            begin
                marks_next = merged_marks;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            marks_reg <= 2'b00;
            eos_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            marks_reg <= marks_next;
            eos_reg   <= eos_next;
        end
    end

    // Result registers and the consumer of the pending head read.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        id_reg     <= id_next;
        pay_reg    <= pay_next;
        if (cmd.fetch)
        begin
            who_reg <= in_consumer;
        end
    end

    assign out_status    = status_reg;
    assign out_sensor_id = id_reg;
    assign out_payload   = pay_reg;

endmodule

// File: dv/drf_checker.sv
// Scoreboard for the two-reader record FIFO: tracks the stream beats and checks every result.
module drf_checker #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [drf_pkg::REC_W-1:0] s_tdata,   // [15:0] sensor_id, [79:16] record_payload
    input  logic [1:0]                s_tuser,   // [0] mode, [1] consumer
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [drf_pkg::REC_W-1:0] m_tdata,   // [15:0] out_sensor_id, [79:16] out_payload
    input  logic [1:0]                m_tuser,   // [1:0] status
    output int                        errors,
    output int                        pending,
    output int                        checked,
    output int                        full_count,
    output int                        eos_count
);

    // One result beat as the FIFO should return it.
    typedef struct packed {
        drf_pkg::status_t          status;
        logic [drf_pkg::ID_W-1:0]  sid;
        logic [drf_pkg::PAY_W-1:0] pay;
    } reply_t;

    // Shadow copy of the FIFO contents and its control state.
    logic [drf_pkg::ID_W-1:0]  id_mem  [DEPTH];
    logic [drf_pkg::PAY_W-1:0] pay_mem [DEPTH];
    int                        head_slot;
    int                        tail_slot;
    int                        held;
    logic [1:0]                read_marks;
    logic                      eos_flag;
    reply_t                    replies_due [$];

    function automatic int slot_after(input int slot);
        return (slot == DEPTH - 1) ? 0 : slot + 1;
    endfunction

    // Applies one request to the shadow FIFO and returns the answer it must produce.
    function automatic reply_t fifo_response(input logic mode, input logic who,
                                             input logic [drf_pkg::ID_W-1:0] sid,
                                             input logic [drf_pkg::PAY_W-1:0] pay);
        reply_t     r;
        logic [1:0] mark;
        r = '{status: drf_pkg::ST_OK, sid: '0, pay: '0};
        if (mode == drf_pkg::MODE_INSERT)
        begin
            if (held >= DEPTH)
            begin
                r.status = drf_pkg::ST_FULL;
            end
            else
            begin
                id_mem[tail_slot]  = sid;
                pay_mem[tail_slot] = pay;
                tail_slot          = slot_after(tail_slot);
                held++;
            end
            return r;
        end
        // An empty store answers retry until the end-of-stream record has been read.
        if (held == 0)
        begin
            r.status = eos_flag ? drf_pkg::ST_NODATA : drf_pkg::ST_RETRY;
            return r;
        end
        mark = who ? 2'b10 : 2'b01;
        if ((read_marks & mark) != 2'b00)
        begin
            r.status = drf_pkg::ST_RETRY;
            return r;
        end
        r.sid      = id_mem[head_slot];
        r.pay      = pay_mem[head_slot];
        read_marks = read_marks | mark;
        // The head leaves only after both consumers have read it.
        if (read_marks == 2'b11)
        begin
            head_slot  = slot_after(head_slot);
            held--;
            read_marks = 2'b00;
        end
        if (r.sid == '0)
        begin
            eos_flag = 1'b1;
            r.status = drf_pkg::ST_NODATA;
        end
        return r;
    endfunction

    // Predict on every accepted request beat and compare every accepted result beat.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            head_slot  = 0;
            tail_slot  = 0;
            held       = 0;
            read_marks = 2'b00;
            eos_flag   = 1'b0;
            replies_due.delete();
            pending    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                want = fifo_response(s_tuser[0], s_tuser[1], s_tdata[drf_pkg::ID_W-1:0],
                                     s_tdata[drf_pkg::REC_W-1:drf_pkg::ID_W]);
                replies_due.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = '{status: drf_pkg::status_t'(m_tuser), sid: m_tdata[drf_pkg::ID_W-1:0],
                        pay: m_tdata[drf_pkg::REC_W-1:drf_pkg::ID_W]};
                checked++;
                if (replies_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: status %0d id %h payload %h",
                                 m_tuser, got.sid, got.pay);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected status %0d id %h payload %h, ",
                                      "got status %0d id %h payload %h"},
                                     want.status, want.sid, want.pay,
                                     m_tuser, got.sid, got.pay);
                    end
                    if (want.status == drf_pkg::ST_FULL)
                        full_count++;
                    if (want.status == drf_pkg::ST_NODATA)
                        eos_count++;
                end
            end
            pending = replies_due.size();
        end
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the two-reader record FIFO: clock, reset, stimulus phases and verdict.
module tb_top;

    localparam int DEPTH        = 16;
    localparam int LIMIT        = 200000;
    localparam int RANDOM_ITEMS = 350;  // per idling phase

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [drf_pkg::REC_W-1:0] s_tdata  = '0;   // [15:0] sensor_id, [79:16] record_payload
    logic [1:0]                s_tuser  = '0;   // [0] mode, [1] consumer
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [drf_pkg::REC_W-1:0] m_tdata;         // [15:0] out_sensor_id, [79:16] out_payload
    logic [1:0]                m_tuser;         // [1:0] status

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent           = 0;
    int cycle_count    = 0;
    int errors;
    int pending;
    int checked;
    int full_count;
    int eos_count;

    dual_reader_fifo #(.DEPTH(DEPTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    drf_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .full_count (full_count),
        .eos_count  (eos_count)
    );

    // Free-running clock with a period of two time units.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The result side stalls at random according to the current phase.
    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one request beat, with random idle cycles first, and returns after it is taken.
    task automatic send_req(input logic mode, input logic who,
                            input logic [drf_pkg::ID_W-1:0] sid,
                            input logic [drf_pkg::PAY_W-1:0] pay);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = {who, mode};
        s_tdata  = {pay, sid};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent++;
    endtask

    // Random traffic in segments that lean toward filling, balancing or draining the FIFO.
    task automatic run_random(input int count);
        int                        left;
        int                        seg;
        int                        insert_pct;
        int                        pick;
        logic [drf_pkg::ID_W-1:0]  sid;
        logic [drf_pkg::PAY_W-1:0] pay;
        left = count;
        while (left > 0)
        begin
            case ($urandom_range(2))
                0:       insert_pct = 15;
                1:       insert_pct = 50;
                default: insert_pct = 85;
            endcase
            seg = $urandom_range(60, 20);
            for (int k = 0; k < seg && left > 0; k++)
            begin
                pick = $urandom_range(15);
                sid  = (pick == 0) ? '0 : (pick == 1) ? '1 : drf_pkg::ID_W'($urandom);
                pick = $urandom_range(15);
                pay  = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
                send_req(($urandom_range(99) < insert_pct) ? drf_pkg::MODE_INSERT
                                                           : drf_pkg::MODE_REMOVE,
                         1'($urandom), sid, pay);
                left--;
            end
        end
    endtask

    // Reset, directed cases, then four idling phases of random traffic.
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty store before any end-of-stream record answers retry.
        send_req(drf_pkg::MODE_REMOVE, 1'b0, '0, '0);
        send_req(drf_pkg::MODE_REMOVE, 1'b1, '0, '0);
        // A record with extreme fields, then an end-of-stream record.
        send_req(drf_pkg::MODE_INSERT, 1'b1, '1, '1);
        send_req(drf_pkg::MODE_INSERT, 1'b0, '0, 64'h0123_4567_89ab_cdef);
        // The same consumer reading the head twice gets a retry.
        send_req(drf_pkg::MODE_REMOVE, 1'b0, '0, '0);
        send_req(drf_pkg::MODE_REMOVE, 1'b0, '0, '0);
        send_req(drf_pkg::MODE_REMOVE, 1'b1, '0, '0);
        // Reading the end-of-stream record sets the sticky flag.
        send_req(drf_pkg::MODE_REMOVE, 1'b1, '0, '0);
        send_req(drf_pkg::MODE_REMOVE, 1'b1, '0, '0);
        send_req(drf_pkg::MODE_REMOVE, 1'b0, '0, '0);
        // Empty store after end of stream answers no data.
        send_req(drf_pkg::MODE_REMOVE, 1'b0, '0, '0);
        send_req(drf_pkg::MODE_REMOVE, 1'b1, '0, '0);
        // Inserts still work after end of stream.
        send_req(drf_pkg::MODE_INSERT, 1'b0, 16'h0001, '0);
        send_req(drf_pkg::MODE_REMOVE, 1'b1, '0, '0);
        send_req(drf_pkg::MODE_REMOVE, 1'b0, '0, '0);

        // Fill to the top, one refused insert, then drain with alternating readers.
        for (int k = 0; k < DEPTH + 1; k++)
            send_req(drf_pkg::MODE_INSERT, k[0], drf_pkg::ID_W'(16'h0100 + k),
                     {$urandom, $urandom});
        for (int k = 0; k < 2 * DEPTH; k++)
            send_req(drf_pkg::MODE_REMOVE, k[0], '0, '0);

        for (int p = 0; p < 4; p++)
        begin
            // Hold off until every outstanding result has come back.
            s_tvalid = 1'b0;
            while (pending != 0)
                @(negedge clk);
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            run_random(RANDOM_ITEMS);
        end

        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run covered %0d requests in four idle/stall phases, %0d results compared.",
                 sent, checked);
        $display("Refused inserts: %0d, no-data answers: %0d, mismatches: %0d.",
                 full_count, eos_count, errors);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: dual_reader_fifo.f
rtl/core/drf_pkg.sv
rtl/core/drf_ram.sv
rtl/core/drf_ctrl.sv
rtl/core/drf_dp.sv
rtl/core/dual_reader_fifo.sv
dv/drf_checker.sv
dv/tb_top.sv
